// ----- src/rfpw_pkg.sv -----
// Shared types, codes and colour helpers for the rectangle fill pixel writer.
// No dependencies.
package rfpw_pkg;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [1:0] CFG_BUFFER_BASE    = 2'd0;
    localparam logic [1:0] CFG_HRES           = 2'd1;
    localparam logic [1:0] CFG_RESAMPLER_MODE = 2'd2;

    localparam logic [15:0] HRES_RST           = 16'd320;
    localparam logic [5:0]  RESAMPLER_MODE_RST = 6'h14;
    localparam logic [15:0] HALF_RES_WIDTH     = 16'd160;

    // Offset holds (row << stride) + (col << 1) for strides up to 12
    localparam int OFFSET_W    = 25;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        DEPTH_OTHER,
        DEPTH_8,
        DEPTH_16
    } depth_t;

    typedef struct packed {
        logic        command;
        logic [11:0] x_pos;
        logic [11:0] y_pos;
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic [23:0] rgb_color;
    } cmd_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic [15:0]         data;
        logic                last;
    } wr_desc_t;

    function automatic depth_t depth_class(input logic [5:0] mode);
        depth_t d;
        unique case (mode) inside
            6'h07, 6'h11, 6'h31:
                d = DEPTH_8;
            6'h00, 6'h12, 6'h17, 6'h19, 6'h32, 6'h37, 6'h39:
                d = DEPTH_OTHER;
            default:
                d = DEPTH_16;
        endcase
        return d;
    endfunction

    function automatic logic [15:0] convert_colour(input depth_t d, input logic [23:0] c);
        logic [15:0] p;
        case (d)
            DEPTH_8:  p = {c[23:21], c[15:13], c[7:6], c[23:21], c[15:13], c[7:6]};
            DEPTH_16: p = {c[23:19], c[15:10], c[7:3]};
            default:  p = c[15:0];
        endcase
        return p;
    endfunction

endpackage

// ----- src/rfpw_front.sv -----
// Command front end: decodes start and tick transactions, holds the rectangle walk state
// and pushes one write descriptor per tick. Depends on rfpw_pkg.
module rfpw_front #(
    parameter int ROW_STRIDE_LOG2 = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rfpw_pkg::cmd_t    cmd,
    input  logic [15:0]       hres,
    input  logic [5:0]        resampler_mode,
    input  logic              queue_full,
    output logic              push,
    output rfpw_pkg::wr_desc_t push_desc
);
    import rfpw_pkg::*;

    localparam int SHIFT_W = $clog2(ROW_STRIDE_LOG2 + 1);

    logic               busy_reg,      busy_next;
    logic [11:0]        cur_row_reg,   cur_row_next;
    logic [11:0]        cur_col_reg,   cur_col_next;
    logic [11:0]        first_col_reg, first_col_next;
    logic [11:0]        end_col_reg,   end_col_next;
    logic [11:0]        end_row_reg,   end_row_next;
    logic [15:0]        pixel_reg,     pixel_next;
    logic [SHIFT_W-1:0] shift_reg,     shift_next;

    depth_t             depth;
    logic               res;
    logic               col8;
    logic [1:0]         xs;
    logic               accept;
    logic               start;
    logic               tick;
    logic signed [13:0] x_ext, y_ext, x_end, y_end;
    logic signed [13:0] x1_raw, y1_raw, x1, y1, x2, y2;
    logic               empty_rect;
    logic               col_end;
    logic               last;

    assign cmd_ready = !queue_full;
    assign accept    = cmd_valid && cmd_ready;
    assign start     = accept && (cmd.command == CMD_START) && !busy_reg;
    assign tick      = accept && (cmd.command == CMD_TICK) && busy_reg;

    assign depth = depth_class(resampler_mode);
    assign res   = (hres == HALF_RES_WIDTH);
    assign col8  = (depth == DEPTH_8);
    assign xs    = {1'b0, res} + {1'b0, col8};

    assign x_ext  = {{2{cmd.x_pos[11]}}, cmd.x_pos};
    assign y_ext  = {{2{cmd.y_pos[11]}}, cmd.y_pos};
    assign x_end  = x_ext + $signed({3'b000, cmd.rect_width}) - 14'sd1;
    assign y_end  = y_ext + $signed({3'b000, cmd.rect_height}) - 14'sd1;
    assign x1_raw = x_ext >>> xs;
    assign y1_raw = y_ext >>> res;
    assign x2     = x_end >>> xs;
    assign y2     = y_end >>> res;
    assign x1     = x1_raw[13] ? 14'sd0 : x1_raw;
    assign y1     = y1_raw[13] ? 14'sd0 : y1_raw;
    assign empty_rect = (x2 < x1) || (y2 < y1);

    assign col_end = (cur_col_reg == end_col_reg);
    assign last    = col_end && (cur_row_reg == end_row_reg);

    assign push             = tick;
    assign push_desc.offset = (OFFSET_W'(cur_row_reg) << shift_reg)
                            + OFFSET_W'({cur_col_reg, 1'b0});
    assign push_desc.data   = pixel_reg;
    assign push_desc.last   = last;

    always_comb
    begin
        busy_next      = busy_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        first_col_next = first_col_reg;
        end_col_next   = end_col_reg;
        end_row_next   = end_row_reg;
        pixel_next     = pixel_reg;
        shift_next     = shift_reg;
        if (start && !empty_rect)
        begin
            busy_next      = 1'b1;
            cur_row_next   = y1[11:0];
            cur_col_next   = x1[11:0];
            first_col_next = x1[11:0];
            end_col_next   = x2[11:0];
            end_row_next   = y2[11:0];
            pixel_next     = convert_colour(depth, cmd.rgb_color);
            shift_next     = SHIFT_W'(ROW_STRIDE_LOG2) - SHIFT_W'(res) - SHIFT_W'(col8);
        end
        else if (tick)
        begin
            if (last)
            begin
                busy_next = 1'b0;
            end
            else if (col_end)
            begin
                cur_col_next = first_col_reg;
                cur_row_next = cur_row_reg + 12'd1;
            end
            else
            begin
                cur_col_next = cur_col_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            first_col_reg <= '0;
            end_col_reg   <= '0;
            end_row_reg   <= '0;
            pixel_reg     <= '0;
            shift_reg     <= SHIFT_W'(ROW_STRIDE_LOG2);
        end
        else
        begin
            busy_reg      <= busy_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            first_col_reg <= first_col_next;
            end_col_reg   <= end_col_next;
            end_row_reg   <= end_row_next;
            pixel_reg     <= pixel_next;
            shift_reg     <= shift_next;
        end
    end

    a_walk_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cur_row_reg <= end_row_reg) && (cur_col_reg <= end_col_reg))
        else $error("walk position beyond rectangle end");

    a_last_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_desc.last) |=> !busy_reg)
        else $error("still busy after last write");

    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !empty_rect) |=> busy_reg)
        else $error("non-empty start did not set busy");

endmodule

// ----- src/rfpw_queue.sv -----
// Short descriptor queue between the command front end and the write back end.
// Depends on rfpw_pkg.
module rfpw_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rfpw_pkg::wr_desc_t push_desc,
    output logic               full,
    input  logic               pop,
    output rfpw_pkg::wr_desc_t pop_desc,
    output logic               empty
);
    import rfpw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    wr_desc_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_desc = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/rfpw_back.sv -----
// Write back end: adds the framebuffer base to queued offsets into the output register.
// Depends on rfpw_pkg.
module rfpw_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        buffer_base,
    input  logic               queue_empty,
    input  rfpw_pkg::wr_desc_t queue_desc,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        write_address,
    output logic [15:0]        write_data,
    output logic               last_write
);
    import rfpw_pkg::*;

    logic        valid_reg, valid_next;
    logic [31:0] addr_reg;
    logic [15:0] data_reg;
    logic        last_reg;

    assign pop        = !queue_empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);

    assign out_valid     = valid_reg;
    assign write_address = addr_reg;
    assign write_data    = data_reg;
    assign last_write    = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg <= buffer_base + 32'(queue_desc.offset);
            data_reg <= queue_desc.data;
            last_reg <= queue_desc.last;
        end
    end

endmodule

// ----- src/rect_fill_pixel_writer.sv -----
// Top level of the rectangle fill pixel writer: configuration registers and stream ports.
// Depends on rfpw_pkg, rfpw_front, rfpw_queue and rfpw_back.
//
//  channel | signals                              | carries
//  s       | s_tvalid s_tready s_tdata s_tuser    | start or tick command
//  m       | m_tvalid m_tready m_tdata m_tlast    | halfword pixel write
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// One command per cycle while the queue is not full; a tick is written into the queue when
// accepted, and its write then passes through the output register (base add) onto m.
// A four-entry descriptor queue plus the output register absorb m-side stalls;
// s_tready drops only when the queue is full. Config writes always complete at once.
// Reset clears the walk state and loads the register defaults.
module rect_fill_pixel_writer #(
    parameter int ROW_STRIDE_LOG2 = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_pos[11:0], y_pos[23:12], rect_width[34:24], rect_height[45:35], rgb_color[69:46]
    input  logic [71:0] s_tdata,
    // command[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // write_address[31:0], write_data[47:32]
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rfpw_pkg::*;

    logic [31:0] buffer_base_reg;
    logic [15:0] hres_reg;
    logic [5:0]  resampler_mode_reg;

    cmd_t        cmd;
    logic        push, pop, full, empty;
    wr_desc_t    push_desc, pop_desc;
    logic [31:0] write_address;
    logic [15:0] write_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_base_reg    <= '0;
            hres_reg           <= HRES_RST;
            resampler_mode_reg <= RESAMPLER_MODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BUFFER_BASE:    buffer_base_reg    <= cfg_data;
                CFG_HRES:           hres_reg           <= cfg_data[15:0];
                CFG_RESAMPLER_MODE: resampler_mode_reg <= cfg_data[5:0];
                default:            ;
            endcase
        end
    end

    assign cmd.command     = s_tuser;
    assign cmd.x_pos       = s_tdata[11:0];
    assign cmd.y_pos       = s_tdata[23:12];
    assign cmd.rect_width  = s_tdata[34:24];
    assign cmd.rect_height = s_tdata[45:35];
    assign cmd.rgb_color   = s_tdata[69:46];

    rfpw_front #(
        .ROW_STRIDE_LOG2 (ROW_STRIDE_LOG2)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (s_tvalid),
        .cmd_ready      (s_tready),
        .cmd            (cmd),
        .hres           (hres_reg),
        .resampler_mode (resampler_mode_reg),
        .queue_full     (full),
        .push           (push),
        .push_desc      (push_desc)
    );

    rfpw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (full),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .empty     (empty)
    );

    rfpw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .buffer_base   (buffer_base_reg),
        .queue_empty   (empty),
        .queue_desc    (pop_desc),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .write_address (write_address),
        .write_data    (write_data),
        .last_write    (m_tlast)
    );

    assign m_tdata = {write_data, write_address};

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for rect_fill_pixel_writer: drives start and tick commands, predicts
// every halfword write from its own model of the fill walk and compares on the m side.
// Depends on rfpw_pkg and the rect_fill_pixel_writer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfpw_pkg::*;

    localparam int ROW_STRIDE_LOG2 = 10;

    localparam logic [5:0] MODE_8B_A  = 6'h07;
    localparam logic [5:0] MODE_8B_B  = 6'h11;
    localparam logic [5:0] MODE_8B_C  = 6'h31;
    localparam logic [5:0] MODE_RAW_A = 6'h00;
    localparam logic [5:0] MODE_RAW_B = 6'h12;
    localparam logic [5:0] MODE_RAW_C = 6'h17;
    localparam logic [5:0] MODE_RAW_D = 6'h19;
    localparam logic [5:0] MODE_RAW_E = 6'h32;
    localparam logic [5:0] MODE_RAW_F = 6'h37;
    localparam logic [5:0] MODE_RAW_G = 6'h39;
    localparam logic [5:0] MODE_MAX   = 6'h3F;

    typedef struct packed {
        logic        command;
        logic [11:0] x_pos;
        logic [11:0] y_pos;
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic [23:0] rgb_color;
    } fill_cmd_t;

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] data;
        logic        last;
    } pixel_write_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_BUFFER_BASE;
    logic [31:0] cfg_data  = '0;

    // register shadow
    logic [31:0] base_cfg  = '0;
    logic [15:0] width_cfg = HRES_RST;
    logic [5:0]  mode_cfg  = RESAMPLER_MODE_RST;

    // walk state of the fill
    logic        fill_busy  = 1'b0;
    logic [11:0] row_at     = '0;
    logic [11:0] col_at     = '0;
    logic [11:0] col_first  = '0;
    logic [11:0] col_end    = '0;
    logic [11:0] row_end    = '0;
    logic [15:0] pixel_word = '0;
    int          row_shift  = ROW_STRIDE_LOG2;

    fill_cmd_t    cmds_pending[$];
    pixel_write_t writes_due[$];
    fill_cmd_t    on_bus;

    int gen_left  = 0;   // ticks still owed to the latched rectangle
    int gen_count = 0;
    int idle_mode = 0;   // 0: sender 28 / receiver 82, 1: swapped, 2: no idling
    int fails     = 0;
    int results_seen = 0;
    int hold_left    = 0;

    rect_fill_pixel_writer #(
        .ROW_STRIDE_LOG2(ROW_STRIDE_LOG2)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic depth_t depth_of(input logic [5:0] mode);
        case (mode)
            MODE_8B_A, MODE_8B_B, MODE_8B_C:
                return DEPTH_8;
            MODE_RAW_A, MODE_RAW_B, MODE_RAW_C, MODE_RAW_D, MODE_RAW_E, MODE_RAW_F, MODE_RAW_G:
                return DEPTH_OTHER;
            default:
                return DEPTH_16;
        endcase
    endfunction

    function automatic logic [15:0] pixel_of(input depth_t d, input logic [23:0] rgb);
        logic [31:0] c;
        logic [7:0]  b;
        c = 32'(rgb);
        b = 8'(((c >> 16) & 32'hE0) | ((c >> 11) & 32'h1C) | ((c >> 6) & 32'h03));
        case (d)
            DEPTH_8:  return {b, b};
            DEPTH_16: return 16'(((c >> 8) & 32'hF800) | ((c >> 5) & 32'h07E0) | ((c >> 3) & 32'h1F));
            default:  return rgb[15:0];
        endcase
    endfunction

    // clipped corners under the current settings; 0 when nothing is covered
    function automatic logic fill_span(input fill_cmd_t c, output int x1, output int y1,
                                       output int x2, output int y2, output int stride);
        int xs;
        int ys;
        int narrow;
        narrow = (depth_of(mode_cfg) == DEPTH_8) ? 1 : 0;
        ys = (width_cfg == HALF_RES_WIDTH) ? 1 : 0;
        xs = ys + narrow;
        x1 = int'($signed(c.x_pos)) >>> xs;
        y1 = int'($signed(c.y_pos)) >>> ys;
        x2 = (int'($signed(c.x_pos)) + int'(c.rect_width) - 1) >>> xs;
        y2 = (int'($signed(c.y_pos)) + int'(c.rect_height) - 1) >>> ys;
        if (x1 < 0)
            x1 = 0;
        if (y1 < 0)
            y1 = 0;
        stride = ROW_STRIDE_LOG2 - ys - narrow;
        return !(x2 < x1 || y2 < y1);
    endfunction

    task automatic fill_step(input fill_cmd_t c);
        int x1;
        int y1;
        int x2;
        int y2;
        int stride;
        pixel_write_t w;
        if (c.command == CMD_START) begin
            if (!fill_busy) begin
                if (fill_span(c, x1, y1, x2, y2, stride)) begin
                    col_first  = 12'(x1);
                    col_at     = 12'(x1);
                    row_at     = 12'(y1);
                    col_end    = 12'(x2);
                    row_end    = 12'(y2);
                    pixel_word = pixel_of(depth_of(mode_cfg), c.rgb_color);
                    row_shift  = stride;
                    fill_busy  = 1'b1;
                end
            end
        end
        else if (fill_busy) begin
            w.address = base_cfg + (32'(row_at) << row_shift) + (32'(col_at) << 1);
            w.data    = pixel_word;
            w.last    = (col_at == col_end) && (row_at == row_end);
            writes_due.push_back(w);
            if (w.last)
                fill_busy = 1'b0;
            else if (col_at == col_end) begin
                col_at = col_first;
                row_at = row_at + 12'd1;
            end
            else
                col_at = col_at + 12'd1;
        end
    endtask

    function automatic logic gap_roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready)
                fill_step(on_bus);
            if (!s_tvalid || s_tready) begin
                if (cmds_pending.size() != 0
                    && !gap_roll(idle_mode == 0 ? 28 : (idle_mode == 1 ? 82 : 0))) begin
                    on_bus = cmds_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, on_bus.rgb_color, on_bus.rect_height,
                                 on_bus.rect_width, on_bus.y_pos, on_bus.x_pos};
                    s_tuser  <= on_bus.command;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        pixel_write_t w;
        if (!rst_n)
            m_tready <= 1'b0;
        else begin
            if (m_tvalid && m_tready) begin
                if (writes_due.size() == 0) begin
                    $error("unexpected write transaction: address %h", m_tdata[31:0]);
                    fails++;
                end
                else begin
                    w = writes_due.pop_front();
                    if (m_tdata[31:0] !== w.address) begin
                        $error("write_address: expected %h, got %h", w.address, m_tdata[31:0]);
                        fails++;
                    end
                    if (m_tdata[47:32] !== w.data) begin
                        $error("write_data: expected %h, got %h", w.data, m_tdata[47:32]);
                        fails++;
                    end
                    if (m_tlast !== w.last) begin
                        $error("last_write: expected %b, got %b", w.last, m_tlast);
                        fails++;
                    end
                end
                results_seen++;
                // long back-pressure so the command side fills up
                if (results_seen == 100 || results_seen == 900)
                    hold_left = 300;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !gap_roll(idle_mode == 0 ? 82 : (idle_mode == 1 ? 28 : 0));
        end
    end

    function automatic fill_cmd_t start_cmd(input int x, input int y, input int w, input int h,
                                            input logic [23:0] rgb);
        fill_cmd_t c;
        c.command     = CMD_START;
        c.x_pos       = 12'(x);
        c.y_pos       = 12'(y);
        c.rect_width  = 11'(w);
        c.rect_height = 11'(h);
        c.rgb_color   = rgb;
        return c;
    endfunction

    // mostly small rectangles; a full-range size comes with a corner that clips it short
    function automatic fill_cmd_t random_start();
        fill_cmd_t c;
        c.command   = CMD_START;
        c.rgb_color = 24'($urandom);
        c.x_pos = ($urandom_range(0, 1) != 0) ? 12'($urandom) : 12'($urandom_range(0, 48) - 8);
        c.y_pos = ($urandom_range(0, 1) != 0) ? 12'($urandom) : 12'($urandom_range(0, 48) - 8);
        if ($urandom_range(0, 4) == 0) begin
            c.rect_width = 11'($urandom);
            c.x_pos      = 12'(int'($urandom_range(0, 6)) - int'(c.rect_width));
        end
        else
            c.rect_width = 11'($urandom_range(0, 6));
        if ($urandom_range(0, 4) == 0) begin
            c.rect_height = 11'($urandom);
            c.y_pos       = 12'(int'($urandom_range(0, 6)) - int'(c.rect_height));
        end
        else
            c.rect_height = 11'($urandom_range(0, 6));
        return c;
    endfunction

    task automatic push_item(input fill_cmd_t c);
        int x1;
        int y1;
        int x2;
        int y2;
        int stride;
        cmds_pending.push_back(c);
        gen_count++;
        if (c.command == CMD_TICK) begin
            if (gen_left > 0)
                gen_left--;
        end
        else if (gen_left == 0) begin
            if (fill_span(c, x1, y1, x2, y2, stride))
                gen_left = (x2 - x1 + 1) * (y2 - y1 + 1);
        end
    endtask

    task automatic push_ticks(input int n);
        fill_cmd_t c;
        for (int i = 0; i < n; i++) begin
            c = random_start();
            c.command = CMD_TICK;
            push_item(c);
        end
    endtask

    task automatic random_part(input int n);
        int stop;
        int pick;
        stop = gen_count + n;
        while (gen_count < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                push_item(random_start());
                if ($urandom_range(0, 9) == 0 && gen_left > 1) begin
                    push_ticks($urandom_range(1, gen_left - 1));
                    push_item(random_start());
                end
                push_ticks(gen_left);
                if ($urandom_range(0, 9) == 0)
                    push_ticks(1);
            end
            else if (pick < 85) begin
                push_item(random_start());
                push_ticks($urandom_range(0, gen_left));
            end
            else if (pick < 93)
                push_ticks(1);
            else
                push_item(random_start());
        end
        push_ticks(gen_left);
    endtask

    task automatic settle();
        while (cmds_pending.size() != 0 || s_tvalid || writes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_BUFFER_BASE: base_cfg  = value;
            CFG_HRES:        width_cfg = value[15:0];
            default:         mode_cfg  = value[5:0];
        endcase
    endtask

    initial
    begin
        logic [31:0] base;
        logic [15:0] width;
        logic [5:0]  mode;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 8; ph++) begin
            idle_mode = (ph < 3) ? 0 : ((ph < 6) ? 1 : 2);
            if (ph != 0) begin
                case (ph)
                    1: begin base = 32'hFFFF_F000; width = HALF_RES_WIDTH; mode = MODE_8B_A; end
                    2: begin base = $urandom; width = HRES_RST; mode = MODE_RAW_A; end
                    3: begin base = 32'hFFFF_FFFF; width = 16'hFFFF; mode = MODE_MAX; end
                    4: begin base = 32'h0000_0000; width = 16'h0000; mode = MODE_8B_B; end
                    5: begin base = $urandom; width = HALF_RES_WIDTH; mode = MODE_8B_C; end
                    6: begin base = $urandom; width = HALF_RES_WIDTH; mode = MODE_RAW_B; end
                    default:
                    begin
                        base  = $urandom;
                        width = 16'($urandom_range(158, 162));
                        mode  = 6'($urandom);
                    end
                endcase
                put_reg(CFG_BUFFER_BASE, base);
                put_reg(CFG_HRES, {16'($urandom), width});
                put_reg(CFG_RESAMPLER_MODE, {26'($urandom), mode});
                cfg_valid <= 1'b0;
            end
            if (ph == 0) begin
                push_ticks(1);
                push_item(start_cmd(0, 0, 1, 1, 24'hFFFFFF));
                push_ticks(gen_left + 1);
                push_item(start_cmd(-5, -3, 8, 5, 24'h123456));
                push_ticks(2);
                push_item(start_cmd(1, 1, 1, 1, 24'hABCDEF));
                push_ticks(gen_left);
                push_item(start_cmd(10, 10, 0, 3, 24'h00FF00));
                push_item(start_cmd(-2048, 0, 2047, 1, 24'h0000FF));
                push_item(start_cmd(5, 5, 3, 0, 24'hFF0000));
                push_item(start_cmd(2047, 2047, 1, 1, 24'h000000));
                push_ticks(gen_left);
            end
            if (ph == 2) begin
                push_item(start_cmd(2047, 2047, 2047, 1, 24'($urandom)));
                push_ticks(gen_left);
            end
            if (ph == 5) begin
                push_item(start_cmd(2047, 2047, 1, 2047, 24'($urandom)));
                push_ticks(gen_left);
            end
            random_part(190);
            settle();
        end
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
